// ===== rtl/tsm_pkg.sv =====
// ----------------------------------------------------------------------------
// tsm_pkg
// Shared sizes, command codes and types of the two-way sorted merge block.
// ----------------------------------------------------------------------------
package tsm_pkg;

   localparam int LIST_DEPTH = 32;
   localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

   localparam int TIME_W   = 18;
   localparam int FLAVOR_W = 8;
   localparam int GRAMS_W  = 16;
   localparam int CMD_W    = 2;

   localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
   localparam logic [CMD_W-1:0] CMD_MERGE  = 2'd2;

   typedef struct packed {
      logic [TIME_W-1:0]   sale_time;
      logic [FLAVOR_W-1:0] flavor_code;
      logic [GRAMS_W-1:0]  grams;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   typedef struct packed {
      logic load_a;
      logic load_b;
      logic emit;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic last_pick;
   } dp_status_type;

endpackage

// ===== rtl/tsm_ram.sv =====
// ----------------------------------------------------------------------------
// tsm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tsm_ram #(
   parameter int WIDTH = 42,
   parameter int DEPTH = 32
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tsm_datapath.sv =====
// ----------------------------------------------------------------------------
// tsm_datapath
// List stores, fill counts, overflow flag, merge indices and result register.
// ----------------------------------------------------------------------------
module tsm_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  tsm_pkg::ctrl_cmd_type         cmd,
   output tsm_pkg::dp_status_type        status,
   input  logic [tsm_pkg::TIME_W-1:0]    req_sale_time,
   input  logic [tsm_pkg::FLAVOR_W-1:0]  req_flavor_code,
   input  logic [tsm_pkg::GRAMS_W-1:0]   req_grams,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tsm_pkg::TIME_W-1:0]    rsp_out_time,
   output logic [tsm_pkg::FLAVOR_W-1:0]  rsp_out_flavor,
   output logic [tsm_pkg::GRAMS_W-1:0]   rsp_out_grams,
   output logic                          rsp_from_list_b,
   output logic                          rsp_empty_res,
   output logic                          rsp_overflowed,
   output logic                          rsp_last
);

   logic [tsm_pkg::CNT_W-1:0] count_a_ff, count_a_in;
   logic [tsm_pkg::CNT_W-1:0] count_b_ff, count_b_in;
   logic [tsm_pkg::CNT_W-1:0] idx_a_ff, idx_a_in;
   logic [tsm_pkg::CNT_W-1:0] idx_b_ff, idx_b_in;
   logic                      overflow_ff, overflow_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   tsm_pkg::rec_type          rsp_rec_ff, rsp_rec_in;
   logic                      rsp_from_b_ff, rsp_from_b_in;
   logic                      rsp_empty_ff, rsp_empty_in;
   logic                      rsp_ovf_ff, rsp_ovf_in;
   logic                      rsp_last_ff, rsp_last_in;

   tsm_pkg::rec_type          new_rec;
   tsm_pkg::rec_type          head_a;
   tsm_pkg::rec_type          head_b;
   logic [tsm_pkg::REC_W-1:0] rd_data_a;
   logic [tsm_pkg::REC_W-1:0] rd_data_b;
   logic                      wr_en_a;
   logic                      wr_en_b;
   logic                      full_a;
   logic                      full_b;
   logic                      a_left;
   logic                      b_left;
   logic                      take_a;
   logic                      total_zero;
   logic [tsm_pkg::CNT_W:0]   total;
   logic [tsm_pkg::CNT_W:0]   picked;

   assign new_rec.sale_time   = req_sale_time;
   assign new_rec.flavor_code = req_flavor_code;
   assign new_rec.grams       = req_grams;

   assign full_a  = (count_a_ff == tsm_pkg::CNT_W'(tsm_pkg::LIST_DEPTH));
   assign full_b  = (count_b_ff == tsm_pkg::CNT_W'(tsm_pkg::LIST_DEPTH));
   assign wr_en_a = cmd.load_a && !full_a;
   assign wr_en_b = cmd.load_b && !full_b;

   tsm_ram #(
      .WIDTH (tsm_pkg::REC_W),
      .DEPTH (tsm_pkg::LIST_DEPTH)
   ) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_en_a),
      .wr_addr (count_a_ff[tsm_pkg::IDX_W-1:0]),
      .wr_data (new_rec),
      .rd_addr (idx_a_in[tsm_pkg::IDX_W-1:0]),
      .rd_data (rd_data_a)
   );

   tsm_ram #(
      .WIDTH (tsm_pkg::REC_W),
      .DEPTH (tsm_pkg::LIST_DEPTH)
   ) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_en_b),
      .wr_addr (count_b_ff[tsm_pkg::IDX_W-1:0]),
      .wr_data (new_rec),
      .rd_addr (idx_b_in[tsm_pkg::IDX_W-1:0]),
      .rd_data (rd_data_b)
   );

   // The read address always follows the next index, so the read data is the
   // current head of each list.
   assign head_a = tsm_pkg::rec_type'(rd_data_a);
   assign head_b = tsm_pkg::rec_type'(rd_data_b);

   assign a_left     = (idx_a_ff < count_a_ff);
   assign b_left     = (idx_b_ff < count_b_ff);
   assign take_a     = a_left && (!b_left || (head_a.sale_time < head_b.sale_time));
   assign total      = {1'b0, count_a_ff} + {1'b0, count_b_ff};
   assign picked     = {1'b0, idx_a_ff} + {1'b0, idx_b_ff} + (tsm_pkg::CNT_W + 1)'(1);
   assign total_zero = (total == '0);

   assign status.out_free  = !rsp_valid_ff || !rsp_stall;
   assign status.last_pick = total_zero || (picked == total);

   always_comb begin
      count_a_in  = count_a_ff;
      count_b_in  = count_b_ff;
      idx_a_in    = idx_a_ff;
      idx_b_in    = idx_b_ff;
      overflow_in = overflow_ff;
      if (wr_en_a) begin
         count_a_in = count_a_ff + tsm_pkg::CNT_W'(1);
      end
      if (wr_en_b) begin
         count_b_in = count_b_ff + tsm_pkg::CNT_W'(1);
      end
      if ((cmd.load_a && full_a) || (cmd.load_b && full_b)) begin
         overflow_in = 1'b1;
      end
      if (cmd.emit && !total_zero) begin
         if (take_a) begin
            idx_a_in = idx_a_ff + tsm_pkg::CNT_W'(1);
         end else begin
            idx_b_in = idx_b_ff + tsm_pkg::CNT_W'(1);
         end
      end
      if (cmd.finish) begin
         count_a_in  = '0;
         count_b_in  = '0;
         idx_a_in    = '0;
         idx_b_in    = '0;
         overflow_in = 1'b0;
      end
   end

   always_comb begin
      rsp_rec_in    = rsp_rec_ff;
      rsp_from_b_in = rsp_from_b_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_ovf_in   = overflow_ff;
         rsp_last_in  = status.last_pick;
         rsp_empty_in = total_zero;
         if (total_zero) begin
            rsp_rec_in    = '0;
            rsp_from_b_in = 1'b0;
         end else begin
            rsp_rec_in    = take_a ? head_a : head_b;
            rsp_from_b_in = !take_a;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         idx_a_ff     <= '0;
         idx_b_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         idx_a_ff     <= idx_a_in;
         idx_b_ff     <= idx_b_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_rec_ff    <= rsp_rec_in;
      rsp_from_b_ff <= rsp_from_b_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_ovf_ff    <= rsp_ovf_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_time    = rsp_rec_ff.sale_time;
   assign rsp_out_flavor  = rsp_rec_ff.flavor_code;
   assign rsp_out_grams   = rsp_rec_ff.grams;
   assign rsp_from_list_b = rsp_from_b_ff;
   assign rsp_empty_res   = rsp_empty_ff;
   assign rsp_overflowed  = rsp_ovf_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ===== rtl/tsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsm_ctrl
// Sequencer for loads and merge runs of the two-way sorted merge block.
// ----------------------------------------------------------------------------
module tsm_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [tsm_pkg::CMD_W-1:0]   req_cmd,
   input  tsm_pkg::dp_status_type      status,
   output tsm_pkg::ctrl_cmd_type       cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PREP  = 2'd1;
   localparam logic [1:0] ST_MERGE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in   = state_ff;
      cmd.load_a = 1'b0;
      cmd.load_b = 1'b0;
      cmd.emit   = 1'b0;
      cmd.finish = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  tsm_pkg::CMD_LOAD_A: begin
                     cmd.load_a = 1'b1;
                  end
                  tsm_pkg::CMD_LOAD_B: begin
                     cmd.load_b = 1'b1;
                  end
                  tsm_pkg::CMD_MERGE: begin
                     state_in = ST_PREP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PREP: begin
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.last_pick) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/two_way_sorted_merge.sv =====
// ----------------------------------------------------------------------------
// two_way_sorted_merge
// Loads two time-sorted lists of sale records and merges them into one run.
// ----------------------------------------------------------------------------
// Each req_ word carries a command: append the record to list A, append it to
// list B, or merge. Loads are taken one per cycle and give no rsp_ word; a
// load into a full list is dropped and marks the next merge as overflowed.
// A merge word stalls the request channel until the run is done. After the
// merge is accepted, both list heads are read in a prep state, the merge
// state picks one and the pick goes into the output register; from then on
// one record per cycle follows when the receiver never stalls. The speed is
// set by the single read port of each list store and the one compare of the
// two heads per cycle. On ties list B goes first. Merging two empty lists
// gives one word marked empty. The last word of a run has rsp_last set; the
// counts and the flag then clear. While rsp_stall is high a waiting output
// word holds and the run pauses; loads are still taken while a finished last
// word waits. Reset empties both lists and clears the flag at once; the
// stores need no clearing pass.
// ----------------------------------------------------------------------------
module two_way_sorted_merge (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tsm_pkg::CMD_W-1:0]     req_cmd,
   input  logic [tsm_pkg::TIME_W-1:0]    req_sale_time,
   input  logic [tsm_pkg::FLAVOR_W-1:0]  req_flavor_code,
   input  logic [tsm_pkg::GRAMS_W-1:0]   req_grams,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tsm_pkg::TIME_W-1:0]    rsp_out_time,
   output logic [tsm_pkg::FLAVOR_W-1:0]  rsp_out_flavor,
   output logic [tsm_pkg::GRAMS_W-1:0]   rsp_out_grams,
   output logic                          rsp_from_list_b,
   output logic                          rsp_empty_res,
   output logic                          rsp_overflowed,
   output logic                          rsp_last
);

   tsm_pkg::ctrl_cmd_type  cmd;
   tsm_pkg::dp_status_type status;

   tsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .status    (status),
      .cmd       (cmd)
   );

   tsm_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_sale_time   (req_sale_time),
      .req_flavor_code (req_flavor_code),
      .req_grams       (req_grams),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_time    (rsp_out_time),
      .rsp_out_flavor  (rsp_out_flavor),
      .rsp_out_grams   (rsp_out_grams),
      .rsp_from_list_b (rsp_from_list_b),
      .rsp_empty_res   (rsp_empty_res),
      .rsp_overflowed  (rsp_overflowed),
      .rsp_last        (rsp_last)
   );

endmodule

// ===== tb/tb_two_way_sorted_merge.sv =====
// ----------------------------------------------------------------------------
// tb_two_way_sorted_merge
// Self-checking testbench for the two-way sorted merge block.
// ----------------------------------------------------------------------------
// Record loads into list A and list B and merge commands are sent over the
// request channel. A behavioral copy of both lists predicts every word of
// each merge run. The prediction covers tie order, one-sided lists, full lists
// with dropped loads and the empty merge. Each response word is compared field
// by field with the oldest prediction. Directed cases come first, then a long
// output hold that backs up the input, then random runs of sorted lists with
// some unsorted lists and unused commands mixed in. Both channels idle and
// stall at random until a quiet tail at the end.
// ----------------------------------------------------------------------------
module tb_two_way_sorted_merge;
   timeunit 1ns;
   timeprecision 1ps;

   import tsm_pkg::*;

   localparam int RUN_LIMIT     = 200000;
   localparam int SETTLE_CYCLES = 20;
   localparam int LONG_HOLD     = 300;
   localparam int RANDOM_WORDS  = 25;
   localparam int MAX_TIME      = (1 << TIME_W) - 1;
   localparam int TIME_TOP      = 235959;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [TIME_W-1:0]   out_time;
      logic [FLAVOR_W-1:0] out_flavor;
      logic [GRAMS_W-1:0]  out_grams;
      logic                from_list_b;
      logic                empty_res;
      logic                overflowed;
      logic                last;
   } merge_word_type;

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_stall;
   logic [CMD_W-1:0]    req_cmd         = CMD_LOAD_A;
   logic [TIME_W-1:0]   req_sale_time   = '0;
   logic [FLAVOR_W-1:0] req_flavor_code = '0;
   logic [GRAMS_W-1:0]  req_grams       = '0;
   logic                rsp_valid;
   logic                rsp_stall       = 1'b0;
   logic [TIME_W-1:0]   rsp_out_time;
   logic [FLAVOR_W-1:0] rsp_out_flavor;
   logic [GRAMS_W-1:0]  rsp_out_grams;
   logic                rsp_from_list_b;
   logic                rsp_empty_res;
   logic                rsp_overflowed;
   logic                rsp_last;

   merge_word_type pending_words[$];
   rec_type        held_a[LIST_DEPTH];
   rec_type        held_b[LIST_DEPTH];
   int             held_cnt_a     = 0;
   int             held_cnt_b     = 0;
   bit             held_overflow  = 1'b0;

   int error_count    = 0;
   int words_sent     = 0;
   int cycle_count    = 0;
   int hold_request   = 0;
   int stall_left     = 0;
   bit send_gaps_on   = 1'b1;
   bit rsp_stalls_on  = 1'b1;

   two_way_sorted_merge uut (.*);

   always begin
      #2ns clock = 1'b1;
      #2ns clock = 1'b0;
   end

   task automatic report_error(input string msg);
      error_count++;
      $display("ERROR at %0t: %s", $realtime, msg);
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) begin
         report_error($sformatf("%s got %0h, expected %0h", name, got, want));
      end
   endtask

   task automatic predict_merge_output(input logic [CMD_W-1:0] cmd, input rec_type rec);
      merge_word_type w;
      int             i;
      int             j;
      bit             take_a;
      i = 0;
      j = 0;
      case (cmd)
         CMD_LOAD_A: begin
            if (held_cnt_a < LIST_DEPTH) begin
               held_a[held_cnt_a] = rec;
               held_cnt_a++;
            end else begin
               held_overflow = 1'b1;
            end
         end
         CMD_LOAD_B: begin
            if (held_cnt_b < LIST_DEPTH) begin
               held_b[held_cnt_b] = rec;
               held_cnt_b++;
            end else begin
               held_overflow = 1'b1;
            end
         end
         CMD_MERGE: begin
            if (held_cnt_a + held_cnt_b == 0) begin
               w = '0;
               w.empty_res  = 1'b1;
               w.overflowed = held_overflow;
               w.last       = 1'b1;
               pending_words.push_back(w);
            end
            while (i < held_cnt_a || j < held_cnt_b) begin
               if (i < held_cnt_a && j < held_cnt_b) begin
                  take_a = held_a[i].sale_time < held_b[j].sale_time;
               end else begin
                  take_a = (i < held_cnt_a);
               end
               w = '0;
               if (take_a) begin
                  {w.out_time, w.out_flavor, w.out_grams} = held_a[i];
                  i++;
               end else begin
                  {w.out_time, w.out_flavor, w.out_grams} = held_b[j];
                  w.from_list_b = 1'b1;
                  j++;
               end
               w.overflowed = held_overflow;
               w.last       = (i + j == held_cnt_a + held_cnt_b);
               pending_words.push_back(w);
            end
            held_cnt_a    = 0;
            held_cnt_b    = 0;
            held_overflow = 1'b0;
         end
         default: begin
         end
      endcase
   endtask

   task automatic set_idling(input bit on);
      send_gaps_on = on;
      rsp_stalls_on <= on;
   endtask

   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] t,
                            input logic [FLAVOR_W-1:0] flv, input logic [GRAMS_W-1:0] g);
      if (send_gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_sale_time   <= t;
      req_flavor_code <= flv;
      req_grams       <= g;
      do @(posedge clock); while (req_stall);
      predict_merge_output(cmd, {t, flv, g});
      if (cmd != CMD_UNUSED) begin
         words_sent++;
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_words.size() != 0);
   endtask

   // Loads na records into list A and nb into list B in random interleaving.
   task automatic send_lists(input int na, input int nb, input bit sorted, input bit do_merge);
      int step_max;
      int ta;
      int tb;
      int ia;
      int ib;
      bit pick_a;
      case ($urandom_range(0, 2))
         0:       step_max = 2;
         1:       step_max = 40;
         default: step_max = MAX_TIME / (na + nb + 1);
      endcase
      ta = $urandom_range(0, step_max);
      tb = $urandom_range(0, step_max);
      ia = 0;
      ib = 0;
      while (ia < na || ib < nb) begin
         if ($urandom_range(0, 11) == 0) begin
            send_word(CMD_UNUSED, TIME_W'($urandom), FLAVOR_W'($urandom),
                      GRAMS_W'($urandom));
         end
         if (!sorted) begin
            ta = $urandom_range(0, MAX_TIME);
            tb = $urandom_range(0, MAX_TIME);
         end
         pick_a = (ib >= nb) || (ia < na && $urandom_range(0, 1) == 1);
         if (pick_a) begin
            send_word(CMD_LOAD_A, TIME_W'(ta), FLAVOR_W'($urandom), GRAMS_W'($urandom));
            ia++;
            ta = ta + $urandom_range(0, step_max);
            if (ta > MAX_TIME) ta = MAX_TIME;
         end else begin
            send_word(CMD_LOAD_B, TIME_W'(tb), FLAVOR_W'($urandom), GRAMS_W'($urandom));
            ib++;
            tb = tb + $urandom_range(0, step_max);
            if (tb > MAX_TIME) tb = MAX_TIME;
         end
      end
      if (do_merge) begin
         send_word(CMD_MERGE, TIME_W'($urandom), FLAVOR_W'($urandom), GRAMS_W'($urandom));
      end
   endtask

   task automatic test_empty_merge();
      send_word(CMD_UNUSED, '0, '0, '0);
      send_word(CMD_MERGE, '0, '0, '0);
   endtask

   task automatic test_field_extremes();
      send_word(CMD_LOAD_A, '0, '0, '0);
      send_word(CMD_LOAD_A, TIME_W'(TIME_TOP), '1, '1);
      send_word(CMD_LOAD_B, '0, 8'h5A, 16'hA5A5);
      send_word(CMD_LOAD_B, '1, '1, '1);
      send_word(CMD_UNUSED, '1, '1, '1);
      send_word(CMD_MERGE, '1, '1, '1);
   endtask

   task automatic test_ties();
      send_word(CMD_LOAD_A, 18'd100, 8'h01, 16'h0001);
      send_word(CMD_LOAD_B, 18'd100, 8'h02, 16'h0002);
      send_word(CMD_LOAD_A, 18'd200, 8'h03, 16'h0003);
      send_word(CMD_LOAD_B, 18'd250, 8'h04, 16'h0004);
      send_word(CMD_LOAD_A, 18'd300, 8'h05, 16'h0005);
      send_word(CMD_LOAD_B, 18'd300, 8'h06, 16'h0006);
      send_word(CMD_MERGE, '0, '0, '0);
   endtask

   task automatic test_one_sided();
      send_word(CMD_LOAD_B, 18'd120000, 8'h10, 16'h1000);
      send_word(CMD_LOAD_B, 18'd120001, 8'h11, 16'h1001);
      send_word(CMD_LOAD_B, 18'd235959, 8'h12, 16'h1002);
      send_word(CMD_MERGE, '0, '0, '0);
      send_word(CMD_LOAD_A, 18'd7, 8'h20, 16'h2000);
      send_word(CMD_LOAD_A, 18'd8, 8'h21, 16'h2001);
      send_word(CMD_MERGE, '0, '0, '0);
   endtask

   task automatic test_full_lists();
      send_lists(LIST_DEPTH + 2, LIST_DEPTH + 1, 1'b1, 1'b1);
      send_word(CMD_MERGE, '0, '0, '0);
   endtask

   // The receiver holds off while loads and merges keep coming, so the merge
   // run backs up into the request channel; then the sender waits for all.
   task automatic test_backpressure();
      wait_drained();
      set_idling(1'b0);
      hold_request <= LONG_HOLD;
      send_lists(6, 6, 1'b1, 1'b1);
      send_lists(5, 7, 1'b1, 1'b1);
      send_lists(3, 3, 1'b1, 1'b1);
      wait_drained();
      set_idling(1'b1);
   endtask

   task automatic test_random_runs();
      int start_count;
      int na;
      int nb;
      start_count = words_sent;
      while (words_sent - start_count < RANDOM_WORDS) begin
         set_idling($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 19))
            0: begin
               na = $urandom_range(0, LIST_DEPTH + 3);
               nb = $urandom_range(0, 4);
            end
            1: begin
               na = $urandom_range(0, 4);
               nb = $urandom_range(0, LIST_DEPTH + 3);
            end
            default: begin
               na = $urandom_range(0, 6);
               nb = $urandom_range(0, 6);
            end
         endcase
         send_lists(na, nb, $urandom_range(0, 5) != 0, $urandom_range(0, 9) != 0);
      end
   endtask

   task automatic test_quiet_tail();
      set_idling(1'b0);
      send_lists(4, 5, 1'b1, 1'b1);
      send_lists(2, 3, 1'b1, 1'b1);
      send_word(CMD_MERGE, '0, '0, '0);
   endtask

   initial begin : drive_rsp_stall
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            stall_left = hold_request;
            hold_request <= 0;
         end else if (stall_left == 0 && rsp_stalls_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 13);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_words
      merge_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            report_error($sformatf("unexpected word, time %0d", rsp_out_time));
         end else begin
            want = pending_words.pop_front();
            compare_field("out_time", 32'(rsp_out_time), 32'(want.out_time));
            compare_field("out_flavor", 32'(rsp_out_flavor), 32'(want.out_flavor));
            compare_field("out_grams", 32'(rsp_out_grams), 32'(want.out_grams));
            compare_field("from_list_b", 32'(rsp_from_list_b), 32'(want.from_list_b));
            compare_field("empty_res", 32'(rsp_empty_res), 32'(want.empty_res));
            compare_field("overflowed", 32'(rsp_overflowed), 32'(want.overflowed));
            compare_field("last", 32'(rsp_last), 32'(want.last));
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin : run_tests
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_empty_merge();
      test_field_extremes();
      test_ties();
      test_one_sided();
      test_full_lists();
      test_backpressure();
      test_random_runs();
      test_quiet_tail();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/tsm_pkg.sv
rtl/tsm_ram.sv
rtl/tsm_datapath.sv
rtl/tsm_ctrl.sv
rtl/two_way_sorted_merge.sv
tb/tb_two_way_sorted_merge.sv
